[hw/rtl/hsv_to_rgb_top_macros.svh]
// ---------------------------------------------------------------------------
// hsv_to_rgb_top assertion macros
// Clocked on clk; the first form is gated off while rst is high.
// ---------------------------------------------------------------------------
`ifndef HSV_TO_RGB_TOP_MACROS_SVH
`define HSV_TO_RGB_TOP_MACROS_SVH

// Checked only outside reset
`define HSV_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Checked on every edge, reset included
`define HSV_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

[hw/rtl/hsvrgb_pkg.sv]
// ---------------------------------------------------------------------------
// hsvrgb_pkg
// Shared constants, types and helpers for the HSV to RGB converter.
// ---------------------------------------------------------------------------
`default_nettype none

package hsvrgb_pkg;

  localparam int FRAC_BITS_DEF = 16;
  localparam int SECTOR_W      = 3;

  // Per-pixel control that rides alongside the datapath
  typedef struct packed {
    logic                v_zero;
    logic                s_zero;
    logic [SECTOR_W-1:0] sector;
  } ctl_t;

  // Round a bit count up to whole bytes
  function automatic int byte_pad(input int n);
    return ((n + 7) >> 3) << 3;
  endfunction

endpackage

`default_nettype wire

[hw/rtl/hsvrgb_prep.sv]
// ---------------------------------------------------------------------------
// hsvrgb_prep
// Stage 1: clamp saturation and brightness, wrap hue, split hue*6 into
// sector and fraction.
// ---------------------------------------------------------------------------
`default_nettype none

module hsvrgb_prep #(
  parameter int FRAC_BITS = hsvrgb_pkg::FRAC_BITS_DEF
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic signed [FRAC_BITS+2:0] hue,
  input  logic signed [FRAC_BITS+1:0] saturation,
  input  logic signed [FRAC_BITS+1:0] brightness,
  input  logic        [FRAC_BITS:0]   alpha,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic        [FRAC_BITS:0]   s,
  output logic        [FRAC_BITS:0]   v,
  output logic        [FRAC_BITS-1:0] f,
  output hsvrgb_pkg::ctl_t           ctl,
  output logic        [FRAC_BITS:0]   alpha_q
);
  import hsvrgb_pkg::*;

  localparam int CH_W = FRAC_BITS + 1;
  localparam int SV_W = FRAC_BITS + 2;
  localparam int H6_W = FRAC_BITS + 3;
  localparam logic [CH_W-1:0] ONE = CH_W'(1) << FRAC_BITS;

  function automatic logic [CH_W-1:0] clamp_unit(input logic [SV_W-1:0] x);
    logic [CH_W-1:0] mag;
    mag = x[CH_W-1:0];
    if (x[SV_W-1]) begin
      return '0;
    end else if (mag > ONE) begin
      return ONE;
    end
    return mag;
  endfunction

  logic [FRAC_BITS-1:0] frac;
  logic [H6_W-1:0]      h6;
  logic [CH_W-1:0]      s_c;
  logic [CH_W-1:0]      v_c;

  // hue is wrapped by keeping only the fraction bits
  assign frac = hue[FRAC_BITS-1:0];
  assign h6   = H6_W'({frac, 2'b00}) + H6_W'({frac, 1'b0});
  assign s_c  = clamp_unit(saturation);
  assign v_c  = clamp_unit(brightness);

  assign in_ready = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s          <= s_c;
      v          <= v_c;
      f          <= h6[FRAC_BITS-1:0];
      ctl.sector <= h6[H6_W-1:FRAC_BITS];
      ctl.v_zero <= (v_c == '0);
      ctl.s_zero <= (s_c == '0);
      alpha_q    <= alpha;
    end
  end

endmodule

`default_nettype wire

[hw/rtl/hsvrgb_mul.sv]
// ---------------------------------------------------------------------------
// hsvrgb_mul
// Stages 2 and 3: the truncating products. Stage 2 forms s*f, s*(1-f) and
// p; stage 3 forms q and t from them.
// ---------------------------------------------------------------------------
`default_nettype none

module hsvrgb_mul #(
  parameter int FRAC_BITS = hsvrgb_pkg::FRAC_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [FRAC_BITS:0]   s,
  input  logic [FRAC_BITS:0]   v,
  input  logic [FRAC_BITS-1:0] f,
  input  hsvrgb_pkg::ctl_t     ctl,
  input  logic [FRAC_BITS:0]   alpha,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [FRAC_BITS:0]   v_q,
  output logic [FRAC_BITS:0]   p_q,
  output logic [FRAC_BITS:0]   q_q,
  output logic [FRAC_BITS:0]   t_q,
  output hsvrgb_pkg::ctl_t     ctl_q,
  output logic [FRAC_BITS:0]   alpha_q
);
  import hsvrgb_pkg::*;

  localparam int CH_W = FRAC_BITS + 1;
  localparam int PR_W = 2 * CH_W;
  localparam logic [CH_W-1:0] ONE = CH_W'(1) << FRAC_BITS;

  // stage 2
  logic            a_valid;
  logic            a_ready;
  logic [CH_W-1:0] f_ext;
  logic [PR_W-1:0] prod_sf;
  logic [PR_W-1:0] prod_sfc;
  logic [PR_W-1:0] prod_p;
  logic [CH_W-1:0] sf;
  logic [CH_W-1:0] sfc;
  logic [CH_W-1:0] a_v;
  logic [CH_W-1:0] a_p;
  ctl_t            a_ctl;
  logic [CH_W-1:0] a_alpha;

  // stage 3
  logic [PR_W-1:0] prod_q;
  logic [PR_W-1:0] prod_t;

  assign f_ext    = CH_W'(f);
  assign prod_sf  = PR_W'(s) * PR_W'(f_ext);
  assign prod_sfc = PR_W'(s) * PR_W'(ONE - f_ext);
  assign prod_p   = PR_W'(v) * PR_W'(ONE - s);

  assign a_ready  = !out_valid || out_ready;
  assign in_ready = !a_valid || a_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else if (in_ready) begin
      a_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      sf      <= prod_sf[FRAC_BITS +: CH_W];
      sfc     <= prod_sfc[FRAC_BITS +: CH_W];
      a_p     <= prod_p[FRAC_BITS +: CH_W];
      a_v     <= v;
      a_ctl   <= ctl;
      a_alpha <= alpha;
    end
  end

  assign prod_q = PR_W'(a_v) * PR_W'(ONE - sf);
  assign prod_t = PR_W'(a_v) * PR_W'(ONE - sfc);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (a_ready) begin
      out_valid <= a_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (a_valid && a_ready) begin
      q_q     <= prod_q[FRAC_BITS +: CH_W];
      t_q     <= prod_t[FRAC_BITS +: CH_W];
      p_q     <= a_p;
      v_q     <= a_v;
      ctl_q   <= a_ctl;
      alpha_q <= a_alpha;
    end
  end

endmodule

`default_nettype wire

[hw/rtl/hsvrgb_sel.sv]
// ---------------------------------------------------------------------------
// hsvrgb_sel
// Stage 4: sector routing and the black / grey exits into the output
// register.
// ---------------------------------------------------------------------------
`default_nettype none

module hsvrgb_sel #(
  parameter int FRAC_BITS = hsvrgb_pkg::FRAC_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [FRAC_BITS:0] v,
  input  logic [FRAC_BITS:0] p,
  input  logic [FRAC_BITS:0] q,
  input  logic [FRAC_BITS:0] t,
  input  hsvrgb_pkg::ctl_t   ctl,
  input  logic [FRAC_BITS:0] alpha,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [FRAC_BITS:0] red,
  output logic [FRAC_BITS:0] green,
  output logic [FRAC_BITS:0] blue,
  output logic [FRAC_BITS:0] alpha_out
);
  import hsvrgb_pkg::*;

  localparam int CH_W = FRAC_BITS + 1;

  localparam logic [SECTOR_W-1:0] SEC_RED_YEL = SECTOR_W'(0);
  localparam logic [SECTOR_W-1:0] SEC_YEL_GRN = SECTOR_W'(1);
  localparam logic [SECTOR_W-1:0] SEC_GRN_CYN = SECTOR_W'(2);
  localparam logic [SECTOR_W-1:0] SEC_CYN_BLU = SECTOR_W'(3);
  localparam logic [SECTOR_W-1:0] SEC_BLU_MAG = SECTOR_W'(4);

  logic [CH_W-1:0] r_next;
  logic [CH_W-1:0] g_next;
  logic [CH_W-1:0] b_next;

  always_comb begin
    if (ctl.v_zero) begin
      r_next = '0;
      g_next = '0;
      b_next = '0;
    end else if (ctl.s_zero) begin
      r_next = v;
      g_next = v;
      b_next = v;
    end else begin
      unique case (ctl.sector)
        SEC_RED_YEL: begin r_next = v; g_next = t; b_next = p; end
        SEC_YEL_GRN: begin r_next = q; g_next = v; b_next = p; end
        SEC_GRN_CYN: begin r_next = p; g_next = v; b_next = t; end
        SEC_CYN_BLU: begin r_next = p; g_next = q; b_next = v; end
        SEC_BLU_MAG: begin r_next = t; g_next = p; b_next = v; end
        // magenta to red, and codes that cannot occur
        default:     begin r_next = v; g_next = p; b_next = q; end
      endcase
    end
  end

  assign in_ready = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      red       <= r_next;
      green     <= g_next;
      blue      <= b_next;
      alpha_out <= alpha;
    end
  end

endmodule

`default_nettype wire

[hw/rtl/hsv_to_rgb_top.sv]
// ---------------------------------------------------------------------------
// hsv_to_rgb_top
// HSV plus alpha to RGB plus alpha pixel converter, fixed point, pipelined.
// ---------------------------------------------------------------------------
// Usage
//   Input stream s_axis carries one pixel per transfer: hue (wrapped to its
//   fraction), saturation and brightness (clamped to 0..1) and alpha.
//   Output stream m_axis carries red, green, blue and the copied alpha.
//   Path: a pixel accepted into the prep register passes through the two
//   multiply stages and then the output register before it is presented
//   on m_axis.
//   Throughput: one pixel per cycle while m_axis_tready is high, set by the
//   four-stage pipeline with a register after every multiplier rank.
//   Stalls: each stage holds its item while the next one is full and not
//   ready; bubbles are squeezed out, so s_axis_tready stays high whenever
//   m_axis_tready is high. Nothing is dropped or repeated.
//   Reset: rst (synchronous) empties the pipeline; m_axis_tvalid is low
//   from the first edge after reset.
// ---------------------------------------------------------------------------
`default_nettype none

module hsv_to_rgb_top #(
  parameter  int FRAC_BITS = hsvrgb_pkg::FRAC_BITS_DEF,
  localparam int IN_W      = hsvrgb_pkg::byte_pad(4 * FRAC_BITS + 8),
  localparam int OUT_W     = hsvrgb_pkg::byte_pad(4 * FRAC_BITS + 4)
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             s_axis_tvalid,
  output logic             s_axis_tready,
  // hue, saturation, brightness, alpha (lowest bits first), zero padded
  input  logic [IN_W-1:0]  s_axis_tdata,
  output logic             m_axis_tvalid,
  input  logic             m_axis_tready,
  // red, green, blue, alpha_out (lowest bits first), zero padded
  output logic [OUT_W-1:0] m_axis_tdata
);
  import hsvrgb_pkg::*;

  localparam int CH_W  = FRAC_BITS + 1;
  localparam int HUE_W = FRAC_BITS + 3;
  localparam int SV_W  = FRAC_BITS + 2;
  localparam int SAT_LO = HUE_W;
  localparam int BRI_LO = SAT_LO + SV_W;
  localparam int ALP_LO = BRI_LO + SV_W;

  logic signed [HUE_W-1:0] hue;
  logic signed [SV_W-1:0]  saturation;
  logic signed [SV_W-1:0]  brightness;
  logic        [CH_W-1:0]  alpha;

  assign hue        = s_axis_tdata[HUE_W-1:0];
  assign saturation = s_axis_tdata[SAT_LO +: SV_W];
  assign brightness = s_axis_tdata[BRI_LO +: SV_W];
  assign alpha      = s_axis_tdata[ALP_LO +: CH_W];

  // prep -> mul
  logic                 pm_valid;
  logic                 pm_ready;
  logic [CH_W-1:0]      pm_s;
  logic [CH_W-1:0]      pm_v;
  logic [FRAC_BITS-1:0] pm_f;
  ctl_t                 pm_ctl;
  logic [CH_W-1:0]      pm_alpha;

  // mul -> sel
  logic            ms_valid;
  logic            ms_ready;
  logic [CH_W-1:0] ms_v;
  logic [CH_W-1:0] ms_p;
  logic [CH_W-1:0] ms_q;
  logic [CH_W-1:0] ms_t;
  ctl_t            ms_ctl;
  logic [CH_W-1:0] ms_alpha;

  logic [CH_W-1:0] red;
  logic [CH_W-1:0] green;
  logic [CH_W-1:0] blue;
  logic [CH_W-1:0] alpha_out;

  hsvrgb_prep #(.FRAC_BITS(FRAC_BITS)) u_prep (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (s_axis_tvalid),
    .in_ready   (s_axis_tready),
    .hue        (hue),
    .saturation (saturation),
    .brightness (brightness),
    .alpha      (alpha),
    .out_valid  (pm_valid),
    .out_ready  (pm_ready),
    .s          (pm_s),
    .v          (pm_v),
    .f          (pm_f),
    .ctl        (pm_ctl),
    .alpha_q    (pm_alpha)
  );

  hsvrgb_mul #(.FRAC_BITS(FRAC_BITS)) u_mul (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (pm_valid),
    .in_ready  (pm_ready),
    .s         (pm_s),
    .v         (pm_v),
    .f         (pm_f),
    .ctl       (pm_ctl),
    .alpha     (pm_alpha),
    .out_valid (ms_valid),
    .out_ready (ms_ready),
    .v_q       (ms_v),
    .p_q       (ms_p),
    .q_q       (ms_q),
    .t_q       (ms_t),
    .ctl_q     (ms_ctl),
    .alpha_q   (ms_alpha)
  );

  hsvrgb_sel #(.FRAC_BITS(FRAC_BITS)) u_sel (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (ms_valid),
    .in_ready  (ms_ready),
    .v         (ms_v),
    .p         (ms_p),
    .q         (ms_q),
    .t         (ms_t),
    .ctl       (ms_ctl),
    .alpha     (ms_alpha),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .red       (red),
    .green     (green),
    .blue      (blue),
    .alpha_out (alpha_out)
  );

  assign m_axis_tdata = OUT_W'({alpha_out, blue, green, red});

endmodule

`default_nettype wire

[hw/rtl/hsvrgb_chk.sv]
// ---------------------------------------------------------------------------
// hsvrgb_chk
// Port-level checks for hsv_to_rgb_top, bound onto every instance.
// ---------------------------------------------------------------------------
`default_nettype none

`include "hsv_to_rgb_top_macros.svh"

module hsvrgb_chk #(
  parameter  int FRAC_BITS = hsvrgb_pkg::FRAC_BITS_DEF,
  localparam int IN_W      = hsvrgb_pkg::byte_pad(4 * FRAC_BITS + 8),
  localparam int OUT_W     = hsvrgb_pkg::byte_pad(4 * FRAC_BITS + 4)
) (
  input logic             clk,
  input logic             rst,
  input logic             s_axis_tvalid,
  input logic             s_axis_tready,
  input logic [IN_W-1:0]  s_axis_tdata,
  input logic             m_axis_tvalid,
  input logic             m_axis_tready,
  input logic [OUT_W-1:0] m_axis_tdata
);

  localparam int CH_W = FRAC_BITS + 1;
  localparam logic [CH_W-1:0] ONE = CH_W'(1) << FRAC_BITS;

  logic [CH_W-1:0] red;
  logic [CH_W-1:0] green;
  logic [CH_W-1:0] blue;
  logic            in_seen;

  assign red     = m_axis_tdata[0 +: CH_W];
  assign green   = m_axis_tdata[CH_W +: CH_W];
  assign blue    = m_axis_tdata[2 * CH_W +: CH_W];
  assign in_seen = s_axis_tvalid || (s_axis_tdata != '0);

  // pipeline is emptied by reset
  `HSV_ASSERT_RST(a_rst_empty, rst |=> !m_axis_tvalid, "output valid after reset")

  // a stalled result keeps its value
  `HSV_ASSERT(a_hold, m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata), "stalled output changed")

  // a free sink never holds back the source
  `HSV_ASSERT(a_flow, m_axis_tready |-> s_axis_tready || !in_seen && s_axis_tready, "input stalled with output free")

  // colour channels never exceed one
  `HSV_ASSERT(a_range, m_axis_tvalid |-> (red <= ONE) && (green <= ONE) && (blue <= ONE), "channel above one")

endmodule

bind hsv_to_rgb_top hsvrgb_chk #(.FRAC_BITS(FRAC_BITS)) u_hsvrgb_chk (.*);

`default_nettype wire
